// File: hdl/ede_pkg.sv
package ede_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int DIST_W = 7;

	typedef enum logic [1:0] {
		FUNC_REF    = 2'd0,
		FUNC_QUERY  = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_byte;
	} req_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} rsp_word_t;

	typedef struct packed {
		logic ref_write;
		logic set_overflow;
		logic query_start;
		logic sweep_step;
		logic finish_load;
	} cmd_t;

	typedef struct packed {
		logic query_started;
		logic query_full;
		logic ref_full;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

// File: hdl/ede_ram.sv
module ede_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/ede_ctrl.sv
module ede_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        func,
	output logic              req_stall,
	input  ede_pkg::status_t  st,
	output ede_pkg::cmd_t     cmd
);

	ede_pkg::state_t state_q;
	ede_pkg::state_t state_nxt;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ede_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != ede_pkg::ST_IDLE);
	assign accept    = req_valid && (state_q == ede_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ede_pkg::ST_IDLE: begin
				if (accept) begin
					case (func)
						ede_pkg::FUNC_REF: begin
							if (!st.query_started) begin
								if (st.ref_full) begin
									cmd.set_overflow = 1'b1;
								end else begin
									cmd.ref_write = 1'b1;
								end
							end
						end
						ede_pkg::FUNC_QUERY: begin
							if (st.query_full) begin
								cmd.set_overflow = 1'b1;
							end else begin
								cmd.query_start = 1'b1;
								state_nxt = ede_pkg::ST_SWEEP;
							end
						end
						ede_pkg::FUNC_FINISH: begin
							state_nxt = ede_pkg::ST_FETCH;
						end
						default: begin
						end
					endcase
				end
			end
			ede_pkg::ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last) begin
					state_nxt = ede_pkg::ST_DRAIN;
				end
			end
			ede_pkg::ST_DRAIN: begin
				state_nxt = ede_pkg::ST_IDLE;
			end
			ede_pkg::ST_FETCH: begin
				if (st.out_free) begin
					cmd.finish_load = 1'b1;
					state_nxt = ede_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ede_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/ede_datapath.sv
module ede_datapath #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ede_pkg::cmd_t      cmd,
	input  logic [7:0]         char_byte,
	output ede_pkg::status_t   st,
	output logic               rsp_valid,
	output ede_pkg::rsp_word_t rsp,
	input  logic               rsp_stall
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

	logic [LW-1:0] ref_len_q;
	logic [LW-1:0] ql_q;
	logic          ovf_q;
	logic [7:0]    qbyte_q;
	logic          first_q;
	logic [LW-1:0] rd_j_q;
	logic          valid_s1;
	logic [LW-1:0] j_s1;
	logic [LW-1:0] left_q;
	logic [LW-1:0] diag_q;
	logic          rsp_valid_q;
	ede_pkg::rsp_word_t rsp_q;

	logic [LW-1:0] jm1;
	logic [7:0]    ref_rdata;
	logic [LW-1:0] dp_rdata;
	logic [LW-1:0] dp_raddr;
	logic [LW-1:0] above;
	logic [LW:0]   up1;
	logic [LW:0]   left1;
	logic [LW:0]   dg;
	logic [LW:0]   min_ab;
	logic [LW:0]   min_all;
	logic [LW-1:0] cell_new;
	logic [LW-1:0] dist_val;
	logic [LW+ede_pkg::DIST_W-1:0] dist_ext;

	assign jm1      = rd_j_q - 1'b1;
	assign dp_raddr = cmd.sweep_step ? rd_j_q : ref_len_q;

	ede_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_ref_ram (
		.clk  (clk),
		.we   (cmd.ref_write),
		.waddr(ref_len_q[AW-1:0]),
		.wdata(char_byte),
		.raddr(jm1[AW-1:0]),
		.rdata(ref_rdata)
	);

	ede_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_LEN + 1)
	) u_row_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(j_s1),
		.wdata(cell_new),
		.raddr(dp_raddr),
		.rdata(dp_rdata)
	);

	always_comb begin
		above   = first_q ? j_s1 : dp_rdata;
		up1     = {1'b0, above} + 1'b1;
		left1   = {1'b0, left_q} + 1'b1;
		dg      = {1'b0, diag_q} + {{LW{1'b0}}, (ref_rdata != qbyte_q)};
		min_ab  = (up1 < left1) ? up1 : left1;
		min_all = (min_ab < dg) ? min_ab : dg;
		if (j_s1 == '0) begin
			cell_new = ql_q;
		end else begin
			cell_new = min_all[LW-1:0];
		end
	end

	assign dist_val = (ql_q == '0) ? ref_len_q : dp_rdata;
	assign dist_ext = {{ede_pkg::DIST_W{1'b0}}, dist_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q   <= '0;
			ql_q        <= '0;
			ovf_q       <= 1'b0;
			first_q     <= 1'b0;
			rd_j_q      <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.sweep_step;
			if (cmd.ref_write) begin
				ref_len_q <= ref_len_q + 1'b1;
			end
			if (cmd.set_overflow) begin
				ovf_q <= 1'b1;
			end
			if (cmd.query_start) begin
				ql_q    <= ql_q + 1'b1;
				first_q <= (ql_q == '0);
				rd_j_q  <= '0;
			end
			if (cmd.sweep_step) begin
				rd_j_q <= rd_j_q + 1'b1;
			end
			if (cmd.finish_load) begin
				rsp_valid_q <= 1'b1;
				ref_len_q   <= '0;
				ql_q        <= '0;
				ovf_q       <= 1'b0;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			qbyte_q <= char_byte;
		end
		if (cmd.sweep_step) begin
			j_s1 <= rd_j_q;
		end
		if (valid_s1) begin
			left_q <= cell_new;
			diag_q <= above;
		end
		if (cmd.finish_load) begin
			rsp_q.distance <= dist_ext[ede_pkg::DIST_W-1:0];
			rsp_q.overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign st.query_started = (ql_q != '0);
	assign st.query_full    = (ql_q == LEN_MAX);
	assign st.ref_full      = (ref_len_q == LEN_MAX);
	assign st.sweep_last    = (rd_j_q == ref_len_q);
	assign st.out_free      = !rsp_valid_q || !rsp_stall;

`ifndef SYNTHESIS
	a_cell_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (ql_q != '0))
		else $error("Row cell updated with no query byte taken.");
	a_cell_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (j_s1 <= ref_len_q))
		else $error("Row cell index beyond the reference length.");
	a_lengths_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ql_q <= LEN_MAX) && (ref_len_q <= LEN_MAX))
		else $error("String length beyond the maximum.");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_load |=> (ref_len_q == '0) && (ql_q == '0) && rsp_valid_q)
		else $error("Finish did not clear the lengths or raise a result.");
`endif

endmodule

// File: hdl/edit_distance_engine.sv
// Unit-cost edit distance between a reference string and a query string.
// Requests arrive on req with req_valid and req_stall; results leave on rsp
// with rsp_valid and rsp_stall. A word is taken at a clock edge where valid
// is high and stall is low.
// A reference byte word raises no stall. Reference bytes that come after
// the first query byte are dropped.
// A query byte word walks the stored row, one cell per cycle through the
// row memory, and the next word waits through the sweep and drain states.
// Bytes beyond MAX_LEN on either string are dropped and set the overflow flag.
// A finish word reads the last row cell; when the output register is free,
// the block raises the result valid and clears both lengths and the flag.
// The result sits in an output register. While the receiver stalls, the
// block keeps taking reference and query words; a further finish waits.
// Reset clears the lengths, the flag, the controller and the result valid.
// The string memories hold no reset value and need no clearing pass.
module edit_distance_engine #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ede_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ede_pkg::rsp_word_t rsp
);

	ede_pkg::cmd_t    cmd;
	ede_pkg::status_t st;

	ede_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.func     (req.func),
		.req_stall(req_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ede_datapath #(
		.MAX_LEN(MAX_LEN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.char_byte(req.char_byte),
		.st       (st),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.rsp_stall(rsp_stall)
	);

endmodule

// File: test/edit_distance_engine_test.sv
`timescale 1ns / 100ps

class distance_ledger;
	localparam int CAP = ede_pkg::MAX_LEN_DEF;

	logic [7:0] ref_bytes[CAP];
	int row[CAP + 1];
	int ref_len;
	int query_len;
	bit ovf;
	ede_pkg::rsp_word_t due[$];
	int errors;
	int checked;

	function new();
		ref_len = 0;
		query_len = 0;
		ovf = 1'b0;
		errors = 0;
		checked = 0;
	endfunction

	task report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function void sweep_row(input logic [7:0] q);
		int above;
		int diag;
		int best;
		int cost;
		int j;
		if (query_len >= CAP) begin
			ovf = 1'b1;
			return;
		end
		if (query_len == 0) begin
			for (j = 0; j <= ref_len; j++)
				row[j] = j;
		end
		query_len++;
		diag = row[0];
		row[0] = query_len;
		for (j = 1; j <= ref_len; j++) begin
			above = row[j];
			cost = (ref_bytes[j - 1] == q) ? 0 : 1;
			best = above + 1;
			if (row[j - 1] + 1 < best)
				best = row[j - 1] + 1;
			if (diag + cost < best)
				best = diag + cost;
			row[j] = best;
			diag = above;
		end
	endfunction

	function void note_word(input ede_pkg::req_word_t w);
		ede_pkg::rsp_word_t want;
		case (w.func)
			ede_pkg::FUNC_REF: begin
				if (query_len == 0) begin
					if (ref_len < CAP) begin
						ref_bytes[ref_len] = w.char_byte;
						ref_len++;
					end else begin
						ovf = 1'b1;
					end
				end
			end
			ede_pkg::FUNC_QUERY: begin
				sweep_row(w.char_byte);
			end
			ede_pkg::FUNC_FINISH: begin
				want.distance = 7'((query_len == 0) ? ref_len : row[ref_len]);
				want.overflow = ovf;
				due = {due, want};
				ref_len = 0;
				query_len = 0;
				ovf = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	task check_word(input ede_pkg::rsp_word_t got);
		ede_pkg::rsp_word_t want;
		checked++;
		if (due.size() == 0) begin
			report($sformatf("distance %0d overflow %0b arrived with no result due",
				got.distance, got.overflow));
			return;
		end
		want = due.pop_front();
		if (got.distance !== want.distance)
			report($sformatf("distance %0d, expected %0d", got.distance, want.distance));
		if (got.overflow !== want.overflow)
			report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
	endtask
endclass

module edit_distance_engine_test;

	localparam logic [1:0] FUNC_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ede_pkg::req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ede_pkg::rsp_word_t rsp;

	int idle_pct = 26;
	int items_sent = 0;
	distance_ledger ledger = new();

	edit_distance_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	task automatic send_word(input logic [1:0] f, input logic [7:0] b, input bit counted);
		ede_pkg::req_word_t w;
		w.func = f;
		w.char_byte = b;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ledger.note_word(w);
		if (counted)
			items_sent++;
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) < 6)
			return 8'h61 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 8);
		if (r < 95)
			return $urandom_range(9, 24);
		return $urandom_range(60, 70);
	endfunction

	task automatic run_comparison(input int ref_count, input int query_count, input bit mutate);
		logic [7:0] ref_q[$];
		logic [7:0] query_q[$];
		int r;
		for (int i = 0; i < ref_count; i++)
			ref_q = {ref_q, pick_byte()};
		if (mutate) begin
			foreach (ref_q[i]) begin
				r = $urandom_range(0, 9);
				if (r == 1) begin
					query_q = {query_q, pick_byte()};
					query_q = {query_q, ref_q[i]};
				end else if (r == 2) begin
					query_q = {query_q, pick_byte()};
				end else if (r != 0) begin
					query_q = {query_q, ref_q[i]};
				end
			end
		end else begin
			for (int i = 0; i < query_count; i++)
				query_q = {query_q, pick_byte()};
		end
		foreach (ref_q[i])
			send_word(ede_pkg::FUNC_REF, ref_q[i], 1'b1);
		foreach (query_q[i]) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				send_word(ede_pkg::FUNC_REF, pick_byte(), 1'b0);
			if ($urandom_range(0, 29) == 0)
				send_word(FUNC_SPARE, 8'($urandom_range(0, 255)), 1'b0);
			send_word(ede_pkg::FUNC_QUERY, query_q[i], 1'b1);
		end
		send_word(ede_pkg::FUNC_FINISH, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ede_pkg::FUNC_FINISH, 8'hff, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'h00, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'hff, 1'b1);
		send_word(ede_pkg::FUNC_FINISH, 8'h00, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'h78, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'h79, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'h7a, 1'b1);
		send_word(ede_pkg::FUNC_FINISH, 8'h5a, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'h61, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'h62, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'h63, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'h61, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'h71, 1'b0);
		send_word(ede_pkg::FUNC_QUERY, 8'h78, 1'b1);
		send_word(FUNC_SPARE, 8'h55, 1'b0);
		send_word(ede_pkg::FUNC_QUERY, 8'h63, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'h64, 1'b1);
		send_word(ede_pkg::FUNC_FINISH, 8'haa, 1'b1);
		send_word(ede_pkg::FUNC_REF, 8'hff, 1'b1);
		send_word(ede_pkg::FUNC_QUERY, 8'hff, 1'b1);
		send_word(ede_pkg::FUNC_FINISH, 8'h01, 1'b1);

		run_comparison(66, 66, 1'b0);
		n = 0;
		while (items_sent < 1350) begin
			idle_pct = (n >= 30 && n < 45) ? 0 : 26;
			run_comparison(pick_len(), pick_len(), 1'($urandom_range(0, 1)));
			n++;
		end
		req_valid <= 1'b0;

		while (ledger.due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (ledger.errors == 0 && ledger.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				ledger.check_word(rsp);
			if (!held && ledger.checked == 25) begin
				held = 1'b1;
				hold_left = 900;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < idle_pct);
			end
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: edit_distance_engine.f
hdl/ede_pkg.sv
hdl/ede_ram.sv
hdl/ede_ctrl.sv
hdl/ede_datapath.sv
hdl/edit_distance_engine.sv
test/edit_distance_engine_test.sv
